// ===== hdl/assert_macros.svh =====
// Concurrent assertion shorthands used by the checker file adjm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLKRST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/adjm_pkg.sv =====
package adjm_pkg;

  localparam int NODES = 16;
  localparam int VTX_W = $clog2(NODES);
  localparam int CNT_W = VTX_W + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_WALK   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  typedef struct packed {
    logic ins_edge;
    logic clr_edges;
    logic start_walk;
    logic pend_load;
    logic pend_status;
    logic push;
    logic pop;
    logic emit_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic a_ok;
    logic b_ok;
    logic found;
    logic last_frame;
    logic slot_free;
  } dp_stat_t;

endpackage

// ===== hdl/adjm_ifs.sv =====
interface adjm_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [adjm_pkg::VTX_W-1:0] vertex_a;
  logic [adjm_pkg::VTX_W-1:0] vertex_b;

  modport source (output valid, output op, output vertex_a, output vertex_b, input ready);
  modport sink (input valid, input op, input vertex_a, input vertex_b, output ready);
endinterface

interface adjm_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [adjm_pkg::VTX_W-1:0] visit_vertex;
  logic                      is_last;
  logic                      status;

  modport source (output valid, output visit_vertex, output is_last, output status,
                  input ready);
  modport sink (input valid, input visit_vertex, input is_last, input status,
                output ready);
endinterface

// ===== hdl/adjm_ctrl.sv =====
module adjm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          req_op,
  output logic                req_ready,
  input  adjm_pkg::dp_stat_t  stat,
  output adjm_pkg::ctl_cmd_t  cmd
);
  import adjm_pkg::*;

  state_t state, state_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (op_t'(req_op))
            OP_INSERT: begin
              cmd.ins_edge    = stat.a_ok && stat.b_ok;
              cmd.pend_load   = 1'b1;
              cmd.pend_status = !(stat.a_ok && stat.b_ok);
              state_next      = ST_FLUSH;
            end
            OP_WALK: begin
              if (stat.b_ok) begin
                cmd.start_walk = 1'b1;
                state_next     = ST_WALK;
              end else begin
                cmd.pend_load   = 1'b1;
                cmd.pend_status = 1'b1;
                state_next      = ST_FLUSH;
              end
            end
            OP_CLEAR: begin
              cmd.clr_edges = 1'b1;
              cmd.pend_load = 1'b1;
              state_next    = ST_FLUSH;
            end
            default: ;  // unused opcode: drop silently
          endcase
        end
      end
      ST_WALK: begin
        if (stat.found) begin
          cmd.push = stat.slot_free;
        end else begin
          cmd.pop = 1'b1;
          if (stat.last_frame) state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (stat.slot_free) begin
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== hdl/adjm_datapath.sv =====
module adjm_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [adjm_pkg::CNT_W-1:0] cfg_wdata,
  input  logic [adjm_pkg::VTX_W-1:0] vertex_a,
  input  logic [adjm_pkg::VTX_W-1:0] vertex_b,
  input  adjm_pkg::ctl_cmd_t         cmd,
  output adjm_pkg::dp_stat_t         stat,
  adjm_rsp_if.source                 rsp
);
  import adjm_pkg::*;

  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] lim;
  logic [NODES-1:0] adj [NODES];
  logic [NODES-1:0] visited;
  logic [VTX_W-1:0] stack [NODES];
  logic [CNT_W-1:0] depth;
  logic [VTX_W-1:0] pend_vertex;
  logic             pend_status;
  logic             out_valid;
  logic [VTX_W-1:0] out_vertex;
  logic             out_last;
  logic             out_status;

  logic [VTX_W-1:0] top_idx;
  logic [VTX_W-1:0] top_vtx;
  logic [NODES-1:0] cand;
  logic [VTX_W-1:0] next_vtx;

  assign lim = (vertex_count > CNT_W'(NODES)) ? CNT_W'(NODES) : vertex_count;

  // Neighbors below the frame's resume point are all visited already, so
  // scanning the whole unvisited row gives the same pick as resuming.
  assign top_idx = depth[VTX_W-1:0] - VTX_W'(1);
  assign top_vtx = stack[top_idx];
  assign cand    = adj[top_vtx] & ~visited;

  always_comb begin
    next_vtx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (cand[i]) next_vtx = VTX_W'(i);
    end
  end

  assign stat.a_ok       = {1'b0, vertex_a} < lim;
  assign stat.b_ok       = {1'b0, vertex_b} < lim;
  assign stat.found      = |cand;
  assign stat.last_frame = (depth == CNT_W'(1));
  assign stat.slot_free  = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      visited      <= '0;
      depth        <= '0;
      out_valid    <= 1'b0;
      for (int r = 0; r < NODES; r++) adj[r] <= '0;
    end else begin
      if (cfg_wen) vertex_count <= cfg_wdata;

      if (cmd.clr_edges) begin
        for (int r = 0; r < NODES; r++) adj[r] <= '0;
      end else if (cmd.ins_edge) begin
        adj[vertex_a][vertex_b] <= 1'b1;
        adj[vertex_b][vertex_a] <= 1'b1;
      end

      if (cmd.start_walk) begin
        visited  <= NODES'(1) << vertex_b;
        depth    <= CNT_W'(1);
      end else if (cmd.push) begin
        visited[next_vtx] <= 1'b1;
        depth             <= depth + CNT_W'(1);
      end else if (cmd.pop) begin
        depth <= depth - CNT_W'(1);
      end

      if (cmd.push || cmd.emit_last) out_valid <= 1'b1;
      else if (rsp.ready)            out_valid <= 1'b0;
    end
  end

  // Hold the latest visit back until we know whether another one follows.
  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      stack[0]    <= vertex_b;
      pend_vertex <= vertex_b;
      pend_status <= 1'b0;
    end else if (cmd.push) begin
      stack[depth[VTX_W-1:0]] <= next_vtx;
      pend_vertex             <= next_vtx;
    end else if (cmd.pend_load) begin
      pend_vertex <= '0;
      pend_status <= cmd.pend_status;
    end

    if (cmd.push || cmd.emit_last) begin
      out_vertex <= pend_vertex;
      out_status <= pend_status;
      out_last   <= cmd.emit_last;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.visit_vertex = out_vertex;
  assign rsp.is_last      = out_last;
  assign rsp.status       = out_status;

endmodule

// ===== hdl/adjacency_matrix_dfs.sv =====
// Channel  Dir  Handshake        Payload
// req      in   valid/ready      op, vertex_a, vertex_b
// rsp      out  valid/ready      visit_vertex, is_last, status
// cfg      in   cfg_wen          cfg_wdata (vertex_count)
//
// Insert, clear and a request with a bad index pass through the flush state,
// which registers the result. A traversal makes one stack step (one push or
// pop) per cycle while rsp is not stalled; each step is one adjacency-row
// read plus a 16-bit priority encode against the visited marks.
// Reset (synchronous, active high) clears all edges, the visited marks and
// vertex_count. A stalled rsp holds the walk at the next push.
module adjacency_matrix_dfs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [adjm_pkg::CNT_W-1:0] cfg_wdata,
  adjm_req_if.sink                   req,
  adjm_rsp_if.source                 rsp
);
  import adjm_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  adjm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  adjm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .vertex_a  (req.vertex_a),
    .vertex_b  (req.vertex_b),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

// ===== hdl/adjm_checker.sv =====
`include "assert_macros.svh"

module adjm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [adjm_pkg::VTX_W-1:0] rsp_visit_vertex,
  input logic                       rsp_is_last,
  input logic                       rsp_status
);

  // An error result carries no vertex and closes its command.
  `ASSERT_CLKRST(a_err_shape, clk, rst, rsp_valid && rsp_status |-> rsp_is_last && (rsp_visit_vertex == '0), "error item malformed")
  // A non-final visit means the traversal is still running.
  `ASSERT_CLKRST(a_busy_mid_walk, clk, rst, rsp_valid && !rsp_is_last |-> !req_ready, "req ready during traversal")
  `ASSERT_CLKRST(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_visit_vertex) && $stable(rsp_is_last) && $stable(rsp_status), "stalled item changed")
  `ASSERT_CLK(a_rst_clears, clk, rst |=> !rsp_valid, "rsp valid after reset")

endmodule

bind adjacency_matrix_dfs adjm_checker u_adjm_checker (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_visit_vertex (rsp.visit_vertex),
  .rsp_is_last      (rsp.is_last),
  .rsp_status       (rsp.status)
);
